@@ src/psrl_pkg.sv @@
package psrl_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int ADDR_W   = 32;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 8;
	localparam int WINDOW_W = 16;
	localparam int LIMIT_W  = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
	localparam logic [LIMIT_W-1:0]  BURST_RESET  = 8'd5;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'hFF;
	localparam logic [COUNT_W-1:0]  COUNT_ONE    = 8'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT = 1'b1;

	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [WINDOW_W-1:0] window_t;
	typedef logic [LIMIT_W-1:0]  limit_t;

	// Running summary handed from one slot cell to the next.
	typedef struct packed {
		logic   hit;
		logic   free;
		logic   deny;
		count_t count;
	} chain_t;

endpackage

@@ src/psrl_if.sv @@
interface psrl_req_if;
	import psrl_pkg::*;

	logic  valid;
	logic  ready;
	addr_t src_ip;
	time_t now_ms;

	modport source (output valid, src_ip, now_ms, input ready);
	modport sink (input valid, src_ip, now_ms, output ready);
endinterface

interface psrl_rsp_if;
	import psrl_pkg::*;

	logic   valid;
	logic   ready;
	logic   allow;
	count_t visit_count;
	logic   new_entry;
	logic   table_full;

	modport source (output valid, allow, visit_count, new_entry, table_full, input ready);
	modport sink (input valid, allow, visit_count, new_entry, table_full, output ready);
endinterface

@@ src/psrl_cell.sv @@
module psrl_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             commit,
	input  psrl_pkg::addr_t  src_ip,
	input  psrl_pkg::time_t  now_ms,
	input  psrl_pkg::addr_t  ip_s1,
	input  psrl_pkg::time_t  now_s1,
	input  psrl_pkg::window_t window_ms,
	input  psrl_pkg::limit_t burst_limit,
	input  logic             any_hit,
	input  psrl_pkg::chain_t chain_in,
	output psrl_pkg::chain_t chain_out
);
	import psrl_pkg::*;

	logic   valid_q;
	addr_t  addr_q;
	count_t count_q;
	time_t  start_q;

	logic   hit_s1;
	logic   free_s1;
	logic   deny_s1;
	logic   restart_s1;
	count_t next_count_s1;

	time_t  elapsed;
	logic   in_window;
	logic   take_hit;
	logic   take_free;

	assign elapsed   = now_ms - start_q;
	assign in_window = elapsed < {{(TIME_W-WINDOW_W){1'b0}}, window_ms};

	always_ff @(posedge clk) begin
		if (load) begin
			hit_s1        <= valid_q && (addr_q == src_ip);
			free_s1       <= !valid_q;
			deny_s1       <= in_window && (count_q > burst_limit);
			restart_s1    <= !in_window || (count_q > burst_limit);
			next_count_s1 <= !in_window ? COUNT_ONE :
			                 (count_q == COUNT_MAX) ? COUNT_MAX : count_q + COUNT_ONE;
		end
	end

	assign take_hit  = hit_s1 && !chain_in.hit;
	assign take_free = free_s1 && !chain_in.free && !any_hit;

	always_comb begin
		chain_out.hit   = chain_in.hit || hit_s1;
		chain_out.free  = chain_in.free || free_s1;
		chain_out.deny  = chain_in.deny || (take_hit && deny_s1);
		chain_out.count = chain_in.count | (take_hit ? next_count_s1 : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (commit && take_free) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && take_hit) begin
			count_q <= next_count_s1;
			if (restart_s1) begin
				start_q <= now_s1;
			end
		end else if (commit && take_free) begin
			addr_q  <= ip_s1;
			count_q <= COUNT_ONE;
			start_q <= now_s1;
		end
	end

endmodule

@@ src/per_source_rate_limiter.sv @@
// Only one request word is in work at a time: a new word is accepted once the
// last has been written back, and a stalled result holds the block until the
// output register frees.
// The first step compares the request in every slot cell, the second resolves
// the lowest hit or free slot along the cell chain and writes that slot back.
// Reset clears all slot valid bits and sets window_ms to 1000, burst_limit to 5.
module per_source_rate_limiter #(
	parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	psrl_req_if.sink                      req,
	psrl_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [psrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psrl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import psrl_pkg::*;

	window_t window_q;
	limit_t  limit_q;
	logic    busy_q;
	addr_t   ip_s1;
	time_t   now_s1;

	logic    rsp_valid_q;
	logic    allow_q;
	count_t  count_q;
	logic    new_entry_q;
	logic    full_q;

	logic    load;
	logic    commit;
	chain_t  chain [TABLE_ENTRIES+1];

	assign req.ready = !busy_q;
	assign load      = req.valid && !busy_q;
	assign commit    = busy_q && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			limit_q  <= BURST_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_MS:   window_q <= cfg_data[WINDOW_W-1:0];
				CFG_BURST_LIMIT: limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ip_s1  <= req.src_ip;
			now_s1 <= req.now_ms;
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		psrl_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.load        (load),
			.commit      (commit),
			.src_ip      (req.src_ip),
			.now_ms      (req.now_ms),
			.ip_s1       (ip_s1),
			.now_s1      (now_s1),
			.window_ms   (window_q),
			.burst_limit (limit_q),
			.any_hit     (chain[TABLE_ENTRIES].hit),
			.chain_in    (chain[i]),
			.chain_out   (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			allow_q     <= !chain[TABLE_ENTRIES].deny;
			new_entry_q <= !chain[TABLE_ENTRIES].hit && chain[TABLE_ENTRIES].free;
			full_q      <= !chain[TABLE_ENTRIES].hit && !chain[TABLE_ENTRIES].free;
			count_q     <= chain[TABLE_ENTRIES].hit ? chain[TABLE_ENTRIES].count :
			               chain[TABLE_ENTRIES].free ? COUNT_ONE : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.allow       = allow_q;
	assign rsp.visit_count = count_q;
	assign rsp.new_entry   = new_entry_q;
	assign rsp.table_full  = full_q;

endmodule

@@ src/psrl_checker.sv @@
module psrl_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic                   allow,
	input logic [psrl_pkg::COUNT_W-1:0] visit_count,
	input logic                   new_entry,
	input logic                   table_full
);
	import psrl_pkg::*;

	// A stalled result word keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(allow) && $stable(visit_count)
			&& $stable(new_entry) && $stable(table_full))
		else $error("result word changed while stalled");

	// Only one request is in work at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	a_full_untracked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && table_full |-> allow && visit_count == '0 && !new_entry)
		else $error("full table result is not an untracked allow");

	a_new_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && new_entry |-> allow && visit_count == COUNT_ONE && !table_full)
		else $error("new entry result is inconsistent");

	a_deny_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !allow |-> !new_entry && !table_full && visit_count > COUNT_ONE)
		else $error("denied result is inconsistent");

endmodule

bind per_source_rate_limiter psrl_checker u_psrl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.allow       (rsp.allow),
	.visit_count (rsp.visit_count),
	.new_entry   (rsp.new_entry),
	.table_full  (rsp.table_full)
);

@@ dv/tb_per_source_rate_limiter.sv @@
`timescale 1ns / 1ps

module tb_per_source_rate_limiter;
	import psrl_pkg::*;

	localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
	localparam int POOL_SIZE     = 90;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic   allow;
		count_t visit_count;
		logic   new_entry;
		logic   table_full;
	} rate_verdict_t;

	typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		addr_t                   ip;
		time_t                   stamp;
		logic [CFG_IDX_W-1:0]    index;
		logic [CFG_DATA_W-1:0]   data;
		logic                    typed;
		rate_verdict_t           want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	psrl_req_if req_ch ();
	psrl_rsp_if rsp_ch ();

	per_source_rate_limiter #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the source table and the two registers.
	logic    shadow_used[TABLE_ENTRIES];
	addr_t   shadow_src[TABLE_ENTRIES];
	count_t  shadow_visits[TABLE_ENTRIES];
	time_t   shadow_since[TABLE_ENTRIES];
	window_t shadow_window;
	limit_t  shadow_limit;

	rate_verdict_t pending_verdicts[$];
	script_row_t   script[$];
	addr_t         src_pool[POOL_SIZE];

	int  mismatches = 0;
	int  words_sent = 0;
	int  words_checked = 0;
	int  denied_seen = 0;
	int  full_seen = 0;
	int  ceiling_seen = 0;
	int  writes_done = 0;
	int  quiet_cycles = 0;
	int  hold_request = 0;
	int  hold_left = 0;
	int  stall_left = 0;
	logic calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 45);
	endfunction

	function automatic rate_verdict_t judge_request(addr_t ip, time_t stamp);
		int hit;
		int vacant;
		time_t elapsed;
		count_t visits;
		rate_verdict_t v;
		hit = -1;
		vacant = -1;
		v.allow = 1'b1;
		v.visit_count = '0;
		v.new_entry = 1'b0;
		v.table_full = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (shadow_used[i]) begin
				if (hit < 0 && shadow_src[i] == ip) begin
					hit = i;
				end
			end else if (vacant < 0) begin
				vacant = i;
			end
		end
		if (hit >= 0) begin
			elapsed = stamp - shadow_since[hit];
			visits = shadow_visits[hit];
			if (elapsed < {16'b0, shadow_window}) begin
				if (visits > shadow_limit) begin
					v.allow = 1'b0;
					shadow_since[hit] = stamp;
				end
				if (visits != COUNT_MAX) begin
					visits = visits + COUNT_ONE;
				end
			end else begin
				visits = COUNT_ONE;
				shadow_since[hit] = stamp;
			end
			shadow_visits[hit] = visits;
			v.visit_count = visits;
		end else if (vacant >= 0) begin
			shadow_used[vacant] = 1'b1;
			shadow_src[vacant] = ip;
			shadow_visits[vacant] = COUNT_ONE;
			shadow_since[vacant] = stamp;
			v.visit_count = COUNT_ONE;
			v.new_entry = 1'b1;
		end else begin
			v.table_full = 1'b1;
		end
		return v;
	endfunction

	function automatic void add_request(addr_t ip, time_t stamp, logic typed, logic allow,
			count_t visits, logic created, logic full);
		script_row_t row;
		row.kind = ROW_REQUEST;
		row.ip = ip;
		row.stamp = stamp;
		row.index = '0;
		row.data = '0;
		row.typed = typed;
		row.want.allow = allow;
		row.want.visit_count = visits;
		row.want.new_entry = created;
		row.want.table_full = full;
		script.push_back(row);
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		script_row_t row;
		row.kind = ROW_WRITE;
		row.ip = '0;
		row.stamp = '0;
		row.index = index;
		row.data = data;
		row.typed = 1'b0;
		row.want = '0;
		script.push_back(row);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_request(addr_t ip, time_t stamp, int gap, logic typed,
			rate_verdict_t want);
		rate_verdict_t got;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.src_ip <= ip;
		req_ch.now_ms <= stamp;
		do @(posedge clk); while (!req_ch.ready);
		got = judge_request(ip, stamp);
		pending_verdicts.push_back(typed ? want : got);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_WINDOW_MS) begin
			shadow_window = data[WINDOW_W-1:0];
		end else begin
			shadow_limit = data[LIMIT_W-1:0];
		end
		writes_done++;
	endtask

	task automatic run_phase(window_t window, limit_t limit, int words, time_t start,
			logic hammer, logic calm_phase, int hold);
		time_t stamp;
		addr_t ip;
		int r;
		int span;
		write_register(CFG_WINDOW_MS, window);
		write_register(CFG_BURST_LIMIT, {8'($urandom_range(0, 255)), limit});
		calm = calm_phase;
		hold_request = hold;
		stamp = start;
		span = window;
		for (int n = 0; n < words; n++) begin
			if (hammer) begin
				ip = src_pool[0];
				stamp = stamp + $urandom_range(0, 10);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					ip = src_pool[$urandom_range(0, 39)];
				end else if (r < 90) begin
					ip = src_pool[$urandom_range(0, POOL_SIZE - 1)];
				end else begin
					ip = $urandom;
				end
				r = $urandom_range(0, 99);
				if (r < 55) begin
					stamp = stamp + $urandom_range(0, span / 8 + 1);
				end else if (r < 85) begin
					stamp = stamp + $urandom_range(0, span + span / 2 + 2);
				end else if (r < 95) begin
					stamp = stamp + $urandom_range(0, 3);
				end else begin
					stamp = $urandom;
				end
			end
			if (n == 60) begin
				settle();
			end
			send_request(ip, stamp, calm ? 0 : pick_gap(), 1'b0, '0);
		end
		calm = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!calm) begin
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		rate_verdict_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			words_checked++;
			if (!rsp_ch.allow) denied_seen++;
			if (rsp_ch.table_full) full_seen++;
			if (rsp_ch.visit_count == COUNT_MAX) ceiling_seen++;
			if (pending_verdicts.size() == 0) begin
				$error("result word with no request outstanding");
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (rsp_ch.allow !== want.allow) begin
					$error("allow: expected %0b, got %0b", want.allow, rsp_ch.allow);
					mismatches++;
				end
				if (rsp_ch.visit_count !== want.visit_count) begin
					$error("visit_count: expected %0d, got %0d", want.visit_count,
						rsp_ch.visit_count);
					mismatches++;
				end
				if (rsp_ch.new_entry !== want.new_entry) begin
					$error("new_entry: expected %0b, got %0b", want.new_entry,
						rsp_ch.new_entry);
					mismatches++;
				end
				if (rsp_ch.table_full !== want.table_full) begin
					$error("table_full: expected %0b, got %0b", want.table_full,
						rsp_ch.table_full);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (req_ch.valid && req_ch.ready)
				|| (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL per_source_rate_limiter");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.src_ip = '0;
		req_ch.now_ms = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			shadow_used[i] = 1'b0;
			shadow_src[i] = '0;
			shadow_visits[i] = '0;
			shadow_since[i] = '0;
		end
		shadow_window = WINDOW_RESET;
		shadow_limit = BURST_RESET;
		for (int i = 0; i < POOL_SIZE; i++) begin
			src_pool[i] = $urandom;
		end

		// Defaults: a 1000 ms window and a burst limit of 5.
		add_request(32'h0000_0000, 32'd0, 1'b1, 1'b1, 8'd1, 1'b1, 1'b0);
		add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd1, 1'b1, 1'b0);
		add_request(32'h0000_0000, 32'd5, 1'b1, 1'b1, 8'd2, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd6, 1'b1, 1'b1, 8'd3, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd7, 1'b1, 1'b1, 8'd4, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd8, 1'b1, 1'b1, 8'd5, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd9, 1'b1, 1'b1, 8'd6, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd10, 1'b1, 1'b0, 8'd7, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd1009, 1'b1, 1'b0, 8'd8, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd2009, 1'b1, 1'b1, 8'd1, 1'b0, 1'b0);
		// Elapsed time wraps through zero here.
		add_request(32'hFFFF_FFFF, 32'h0000_03E6, 1'b1, 1'b1, 8'd2, 1'b0, 1'b0);
		add_request(32'hFFFF_FFFF, 32'h0000_03E7, 1'b1, 1'b1, 8'd1, 1'b0, 1'b0);
		// A zero window restarts every known source.
		add_write(CFG_WINDOW_MS, 16'd0);
		add_request(32'h0000_0000, 32'd2009, 1'b1, 1'b1, 8'd1, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd2009, 1'b1, 1'b1, 8'd1, 1'b0, 1'b0);
		add_write(CFG_WINDOW_MS, 16'hFFFF);
		add_write(CFG_BURST_LIMIT, 16'hFF00);
		add_request(32'h0000_0000, 32'd67543, 1'b1, 1'b0, 8'd2, 1'b0, 1'b0);
		add_request(32'h0000_0000, 32'd133078, 1'b1, 1'b1, 8'd1, 1'b0, 1'b0);
		add_request(32'h8000_0001, 32'h7FFF_FFFF, 1'b1, 1'b1, 8'd1, 1'b1, 1'b0);
		add_write(CFG_BURST_LIMIT, 16'h00FF);
		add_request(32'h8000_0001, 32'h8000_0000, 1'b1, 1'b1, 8'd2, 1'b0, 1'b0);
		add_request(32'h1234_5678, 32'hA5A5_A5A5, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);
		add_request(32'h8000_0001, 32'h8000_0001, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				write_register(script[i].index, script[i].data);
			end else begin
				send_request(script[i].ip, script[i].stamp, pick_gap(), script[i].typed,
					script[i].want);
			end
		end

		run_phase(16'd65535, 8'd255, 260, 32'h0010_0000, 1'b1, 1'b1, 0);
		run_phase(16'd65535, 8'd250, 40, 32'h0010_2000, 1'b1, 1'b0, 0);
		run_phase(16'd1, 8'd0, 110, $urandom, 1'b0, 1'b0, 0);
		run_phase(16'd0, 8'($urandom_range(0, 255)), 100, $urandom, 1'b0, 1'b1, 0);
		run_phase(WINDOW_RESET, BURST_RESET, 130, $urandom, 1'b0, 1'b1, 80);
		run_phase(16'($urandom_range(1, 3000)), 8'($urandom_range(0, 10)), 130,
			32'hFFFF_C000, 1'b0, 1'b0, 0);
		run_phase(16'd20, 8'd2, 110, $urandom, 1'b0, 1'b0, 0);
		run_phase(16'd65535, 8'($urandom_range(0, 255)), 100, 32'hFFFF_0000, 1'b0,
			1'b0, 0);

		settle();
		$display("Checked %0d of %0d requests across %0d register writes.",
			words_checked, words_sent, writes_done);
		$display("Seen: %0d denied, %0d untracked with the table full, %0d at count 255.",
			denied_seen, full_seen, ceiling_seen);
		if (mismatches == 0) begin
			$display("PASS per_source_rate_limiter");
		end else begin
			$display("FAIL per_source_rate_limiter");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/psrl_pkg.sv
src/psrl_if.sv
src/psrl_cell.sv
src/per_source_rate_limiter.sv
src/psrl_checker.sv
dv/tb_per_source_rate_limiter.sv
